// File: rtl/core/bppm_pkg.sv
// ----------------------------------------------------------------------------
// bppm_pkg
// Types, codes and sizes shared by the buffer pool pin manager.
// ----------------------------------------------------------------------------
package bppm_pkg;

	// Pool size, clamped to what a four-bit slot index can address.
	localparam int POOL_SLOTS = 16;
	localparam int NSLOTS     = (POOL_SLOTS > 16) ? 16 : ((POOL_SLOTS < 1) ? 1 : POOL_SLOTS);
	localparam int IDX_W      = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;

	// Field widths of the channel payloads.
	localparam int CMD_W   = 3;
	localparam int BLOCK_W = 32;
	localparam int SLOT_W  = 4;
	localparam int STAT_W  = 3;
	localparam int PINS_W  = 8;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_REQUEST = 3'd0;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MARK    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_FLUSH   = 3'd4;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_HIT       = 3'd0;
	localparam logic [STAT_W-1:0] ST_LOADED    = 3'd1;
	localparam logic [STAT_W-1:0] ST_NO_FREE   = 3'd2;
	localparam logic [STAT_W-1:0] ST_RELEASED  = 3'd3;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 3'd4;
	localparam logic [STAT_W-1:0] ST_MARKED    = 3'd5;
	localparam logic [STAT_W-1:0] ST_CLEARED   = 3'd6;
	localparam logic [STAT_W-1:0] ST_FLUSH     = 3'd7;

	localparam logic [PINS_W-1:0] PINS_MAX = '1;

	// One slot of the pool.
	typedef struct packed {
		logic               valid;
		logic [BLOCK_W-1:0] block;
		logic [PINS_W-1:0]  pins;
		logic               dirty;
	} slot_entry_t;

	// Write and clear control from the sequencer to the slot store.
	typedef struct packed {
		logic             we;
		logic             clr;
		logic [IDX_W-1:0] addr;
		slot_entry_t      entry;
	} store_wr_t;

	// One result beat.
	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot_index;
		logic               write_back;
		logic [BLOCK_W-1:0] write_back_block;
		logic               load_needed;
		logic [PINS_W-1:0]  pin_count;
		logic               last;
	} result_t;

endpackage

// File: rtl/core/bppm_req_if.sv
// ----------------------------------------------------------------------------
// bppm_req_if
// Command channel: one beat carries a command, a block id and a slot.
// ----------------------------------------------------------------------------
interface bppm_req_if;
	logic                          valid;
	logic                          ready;
	logic [bppm_pkg::CMD_W-1:0]    command;
	logic [bppm_pkg::BLOCK_W-1:0]  block_id;
	logic [bppm_pkg::SLOT_W-1:0]   slot;

	modport source (output valid, output command, output block_id, output slot, input ready);
	modport sink   (input valid, input command, input block_id, input slot, output ready);
endinterface

// File: rtl/core/bppm_rsp_if.sv
// ----------------------------------------------------------------------------
// bppm_rsp_if
// Result channel: one beat carries one result of a command.
// ----------------------------------------------------------------------------
interface bppm_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [bppm_pkg::STAT_W-1:0]   status;
	logic [bppm_pkg::SLOT_W-1:0]   slot_index;
	logic                          write_back;
	logic [bppm_pkg::BLOCK_W-1:0]  write_back_block;
	logic                          load_needed;
	logic [bppm_pkg::PINS_W-1:0]   pin_count;
	logic                          last;

	modport source (output valid, output status, output slot_index, output write_back,
		output write_back_block, output load_needed, output pin_count, output last,
		input ready);
	modport sink   (input valid, input status, input slot_index, input write_back,
		input write_back_block, input load_needed, input pin_count, input last,
		output ready);
endinterface

// File: rtl/core/bppm_slot_store.sv
// ----------------------------------------------------------------------------
// bppm_slot_store
// Slot state of the pool with one read port, one write port and a clear.
// ----------------------------------------------------------------------------
module bppm_slot_store (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [bppm_pkg::IDX_W-1:0] rd_addr,
	output bppm_pkg::slot_entry_t   rd_entry,
	input  bppm_pkg::store_wr_t     wr
);

	logic                          valid_q [bppm_pkg::NSLOTS];
	logic [bppm_pkg::BLOCK_W-1:0]  block_q [bppm_pkg::NSLOTS];
	logic [bppm_pkg::PINS_W-1:0]   pins_q  [bppm_pkg::NSLOTS];
	logic                          dirty_q [bppm_pkg::NSLOTS];

	// Control marks: reset and clear empty every slot at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bppm_pkg::NSLOTS; i++) begin
				valid_q[i] <= 1'b0;
				pins_q[i]  <= '0;
				dirty_q[i] <= 1'b0;
			end
		end else if (wr.clr) begin
			for (int i = 0; i < bppm_pkg::NSLOTS; i++) begin
				valid_q[i] <= 1'b0;
				pins_q[i]  <= '0;
				dirty_q[i] <= 1'b0;
			end
		end else if (wr.we) begin
			valid_q[wr.addr] <= wr.entry.valid;
			pins_q[wr.addr]  <= wr.entry.pins;
			dirty_q[wr.addr] <= wr.entry.dirty;
		end
	end

	// Block ids are only looked at while the slot is valid, so they keep no reset.
	always_ff @(posedge clk) begin
		if (wr.we && !wr.clr) begin
			block_q[wr.addr] <= wr.entry.block;
		end
	end

	// Single read port, addressed by the sequencer.
	always_comb begin
		rd_entry.valid = valid_q[rd_addr];
		rd_entry.block = block_q[rd_addr];
		rd_entry.pins  = pins_q[rd_addr];
		rd_entry.dirty = dirty_q[rd_addr];
	end

endmodule

// File: rtl/core/bppm_out_stage.sv
// ----------------------------------------------------------------------------
// bppm_out_stage
// Output register that holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module bppm_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  bppm_pkg::result_t  res,
	output logic               out_free,
	bppm_rsp_if.source         rsp
);

	logic               valid_q;
	bppm_pkg::result_t  data_q;

	// The register may be refilled in the same cycle as its beat leaves.
	assign out_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= res;
		end
	end

	assign rsp.valid            = valid_q;
	assign rsp.status           = data_q.status;
	assign rsp.slot_index       = data_q.slot_index;
	assign rsp.write_back       = data_q.write_back;
	assign rsp.write_back_block = data_q.write_back_block;
	assign rsp.load_needed      = data_q.load_needed;
	assign rsp.pin_count        = data_q.pin_count;
	assign rsp.last             = data_q.last;

endmodule

// File: rtl/core/bppm_seq.sv
// ----------------------------------------------------------------------------
// bppm_seq
// Sequencer that walks the slot store one slot a cycle, but for flush stalls,
// through a shared block id comparator, and builds the result beats.
// ----------------------------------------------------------------------------
module bppm_seq (
	input  logic                       clk,
	input  logic                       arst_n,
	bppm_req_if.sink                   req,
	output logic [bppm_pkg::IDX_W-1:0] rd_addr,
	input  bppm_pkg::slot_entry_t      rd_entry,
	output bppm_pkg::store_wr_t        wr,
	input  logic                       out_free,
	output logic                       emit,
	output bppm_pkg::result_t          res
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_GRANT = 3'd2;
	localparam logic [2:0] S_EXEC  = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;
	localparam logic [2:0] S_FDONE = 3'd5;

	localparam logic [bppm_pkg::IDX_W-1:0] LAST_IDX = bppm_pkg::IDX_W'(bppm_pkg::NSLOTS - 1);

	logic [2:0]                     state_q;
	logic [bppm_pkg::CMD_W-1:0]     cmd_q;
	logic [bppm_pkg::BLOCK_W-1:0]   bid_q;
	logic [bppm_pkg::SLOT_W-1:0]    slot_q;
	logic [bppm_pkg::IDX_W-1:0]     idx_q;
	logic                           hit_q;
	logic                           inv_q;
	logic                           unp_q;
	logic [bppm_pkg::IDX_W-1:0]     hit_idx_q;
	logic [bppm_pkg::IDX_W-1:0]     inv_idx_q;
	logic [bppm_pkg::IDX_W-1:0]     unp_idx_q;

	logic                           match;
	logic                           scan_last;
	logic                           slot_ok;
	logic                           flush_item;
	logic [bppm_pkg::IDX_W-1:0]     grant_idx;
	logic [bppm_pkg::PINS_W-1:0]    pin_inc;
	logic                           wb;

	assign req.ready = (state_q == S_IDLE);

	// Shared compare unit and the small decisions around it.
	assign match      = rd_entry.valid && (rd_entry.block == bid_q);
	assign scan_last  = (idx_q == LAST_IDX);
	assign slot_ok    = ({1'b0, slot_q} < 5'(bppm_pkg::NSLOTS));
	assign flush_item = rd_entry.valid && rd_entry.dirty;
	assign pin_inc    = (rd_entry.pins == bppm_pkg::PINS_MAX) ? rd_entry.pins
		: rd_entry.pins + 8'd1;
	assign wb         = rd_entry.valid && rd_entry.dirty;

	// A hit wins, then the first invalid slot, then the first unpinned one.
	always_comb begin
		if (hit_q) begin
			grant_idx = hit_idx_q;
		end else if (inv_q) begin
			grant_idx = inv_idx_q;
		end else begin
			grant_idx = unp_idx_q;
		end
	end

	// Read address of the slot store.
	always_comb begin
		case (state_q)
			S_GRANT: rd_addr = grant_idx;
			S_EXEC:  rd_addr = slot_q[bppm_pkg::IDX_W-1:0];
			default: rd_addr = idx_q;
		endcase
	end

	// Sequencer state and scan bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			idx_q     <= '0;
			hit_q     <= 1'b0;
			inv_q     <= 1'b0;
			unp_q     <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						idx_q <= '0;
						hit_q <= 1'b0;
						inv_q <= 1'b0;
						unp_q <= 1'b0;
						case (req.command)
							bppm_pkg::CMD_REQUEST: state_q <= S_SCAN;
							bppm_pkg::CMD_RELEASE,
							bppm_pkg::CMD_MARK,
							bppm_pkg::CMD_CLEAR:   state_q <= S_EXEC;
							bppm_pkg::CMD_FLUSH:   state_q <= S_FLUSH;
							default:               state_q <= S_IDLE;
						endcase
					end
				end
				S_SCAN: begin
					if (match) begin
						hit_q   <= 1'b1;
						state_q <= S_GRANT;
					end else begin
						if (!rd_entry.valid && !inv_q) begin
							inv_q <= 1'b1;
						end
						if ((rd_entry.pins == '0) && !unp_q) begin
							unp_q <= 1'b1;
						end
						if (scan_last) begin
							state_q <= S_GRANT;
						end else begin
							idx_q <= idx_q + bppm_pkg::IDX_W'(1);
						end
					end
				end
				S_GRANT, S_FDONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_EXEC: begin
					// An out-of-range slot ends release and mark_dirty silently;
					// clear always answers.
					if (out_free || (!slot_ok && cmd_q != bppm_pkg::CMD_CLEAR)) begin
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (!flush_item || out_free) begin
						if (scan_last) begin
							state_q <= S_FDONE;
						end else begin
							idx_q <= idx_q + bppm_pkg::IDX_W'(1);
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command payload and the slot indices found by the scan.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q  <= req.command;
			bid_q  <= req.block_id;
			slot_q <= req.slot;
		end
		if (state_q == S_SCAN) begin
			if (match) begin
				hit_idx_q <= idx_q;
			end
			if (!rd_entry.valid && !inv_q) begin
				inv_idx_q <= idx_q;
			end
			if ((rd_entry.pins == '0) && !unp_q) begin
				unp_idx_q <= idx_q;
			end
		end
	end

	// Slot updates and result beats.
	always_comb begin
		wr       = '0;
		wr.addr  = rd_addr;
		wr.entry = rd_entry;
		emit     = 1'b0;
		res      = '0;
		res.last = 1'b1;
		case (state_q)
			S_GRANT: begin
				if (out_free) begin
					emit           = 1'b1;
					res.slot_index = bppm_pkg::SLOT_W'(grant_idx);
					if (hit_q) begin
						wr.we          = 1'b1;
						wr.entry.pins  = pin_inc;
						res.status     = bppm_pkg::ST_HIT;
						res.pin_count  = pin_inc;
					end else if (inv_q || unp_q) begin
						wr.we                = 1'b1;
						wr.entry.valid       = 1'b1;
						wr.entry.block       = bid_q;
						wr.entry.pins        = pin_inc;
						wr.entry.dirty       = 1'b0;
						res.status           = bppm_pkg::ST_LOADED;
						res.write_back       = wb;
						res.write_back_block = wb ? rd_entry.block : '0;
						res.load_needed      = 1'b1;
						res.pin_count        = pin_inc;
					end else begin
						res.status     = bppm_pkg::ST_NO_FREE;
						res.slot_index = '0;
					end
				end
			end
			S_EXEC: begin
				if (out_free) begin
					case (cmd_q)
						bppm_pkg::CMD_RELEASE: begin
							if (slot_ok) begin
								emit           = 1'b1;
								res.slot_index = slot_q;
								if (rd_entry.pins == '0) begin
									res.status = bppm_pkg::ST_UNDERFLOW;
								end else begin
									wr.we         = 1'b1;
									wr.entry.pins = rd_entry.pins - 8'd1;
									res.status    = bppm_pkg::ST_RELEASED;
									res.pin_count = rd_entry.pins - 8'd1;
								end
							end
						end
						bppm_pkg::CMD_MARK: begin
							if (slot_ok) begin
								emit           = 1'b1;
								wr.we          = 1'b1;
								wr.entry.dirty = 1'b1;
								res.status     = bppm_pkg::ST_MARKED;
								res.slot_index = slot_q;
								res.pin_count  = rd_entry.pins;
							end
						end
						bppm_pkg::CMD_CLEAR: begin
							emit       = 1'b1;
							wr.clr     = 1'b1;
							res.status = bppm_pkg::ST_CLEARED;
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			S_FLUSH: begin
				if (flush_item && out_free) begin
					emit                 = 1'b1;
					wr.we                = 1'b1;
					wr.entry.dirty       = 1'b0;
					res.status           = bppm_pkg::ST_FLUSH;
					res.slot_index       = bppm_pkg::SLOT_W'(idx_q);
					res.write_back       = 1'b1;
					res.write_back_block = rd_entry.block;
					res.pin_count        = rd_entry.pins;
					res.last             = 1'b0;
				end
			end
			S_FDONE: begin
				if (out_free) begin
					emit       = 1'b1;
					res.status = bppm_pkg::ST_FLUSH;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

endmodule

// File: rtl/core/buffer_pool_pin_manager.sv
// ----------------------------------------------------------------------------
// buffer_pool_pin_manager
// Pin-counting manager for a pool of page slots: lookup, victim choice,
// release, dirty marking, clear and flush.
//
//   Channel  Direction  Beat carries
//   req      in         command, block_id, slot
//   rsp      out        status, slot_index, write_back, write_back_block,
//                       load_needed, pin_count, last
//
// A request is accepted, scans the slots one by one (the scan stops at a hit,
// else covers all 16 slots) and is granted. Release, mark_dirty and clear
// run straight from acceptance; flush walks every slot, with a beat for each
// valid dirty one, then a closing beat. The single read port of the slot
// store and its comparator make the scan and the flush walk go one slot at a
// time. Reset empties every slot at once. The output register holds a beat
// while rsp.ready is low, and the grant and the flush walk wait on it.
// ----------------------------------------------------------------------------
module buffer_pool_pin_manager (
	input  logic       clk,
	input  logic       arst_n,
	bppm_req_if.sink   req,
	bppm_rsp_if.source rsp
);

	logic [bppm_pkg::IDX_W-1:0] rd_addr;
	bppm_pkg::slot_entry_t      rd_entry;
	bppm_pkg::store_wr_t        wr;
	logic                       out_free;
	logic                       emit;
	bppm_pkg::result_t          res;

	// Sequencer with the shared comparator.
	bppm_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr       (wr),
		.out_free (out_free),
		.emit     (emit),
		.res      (res)
	);

	// Slot state.
	bppm_slot_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_addr  (rd_addr),
		.rd_entry (rd_entry),
		.wr       (wr)
	);

	// Result register.
	bppm_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit),
		.res      (res),
		.out_free (out_free),
		.rsp      (rsp)
	);

endmodule

// File: rtl/core/bppm_checker.sv
// ----------------------------------------------------------------------------
// bppm_checker
// Port-level checks on the buffer pool pin manager, bound to the top level.
// ----------------------------------------------------------------------------
module bppm_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic [bppm_pkg::CMD_W-1:0]   req_command,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [bppm_pkg::STAT_W-1:0]  rsp_status,
	input logic [bppm_pkg::SLOT_W-1:0]  rsp_slot_index,
	input logic                         rsp_write_back,
	input logic                         rsp_load_needed,
	input logic [bppm_pkg::PINS_W-1:0]  rsp_pin_count,
	input logic                         rsp_last
);

	// A result beat is held until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result beat dropped before it was taken");

	// An accepted command with a known code keeps the block busy for at least the next cycle.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_command == bppm_pkg::CMD_REQUEST
		|| req_command == bppm_pkg::CMD_RELEASE || req_command == bppm_pkg::CMD_MARK
		|| req_command == bppm_pkg::CMD_CLEAR || req_command == bppm_pkg::CMD_FLUSH)
		|=> !req_ready)
		else $error("command accepted while the previous one is still at work");

	// Only flush items leave last low, and they always carry a write-back.
	a_flush_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == bppm_pkg::ST_FLUSH && rsp_write_back)
		else $error("non-final beat that is not a flush item");

	// A full pool grants nothing.
	a_no_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bppm_pkg::ST_NO_FREE |->
		rsp_slot_index == '0 && rsp_pin_count == '0 && !rsp_load_needed && rsp_last)
		else $error("no-free-slot beat carries a grant");

	// A hit never loads or writes back, and leaves the slot pinned.
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == bppm_pkg::ST_HIT |->
		!rsp_write_back && !rsp_load_needed && rsp_pin_count != '0)
		else $error("hit beat with a transfer or an unpinned slot");

endmodule

bind buffer_pool_pin_manager bppm_checker u_bppm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_command     (req.command),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_status      (rsp.status),
	.rsp_slot_index  (rsp.slot_index),
	.rsp_write_back  (rsp.write_back),
	.rsp_load_needed (rsp.load_needed),
	.rsp_pin_count   (rsp.pin_count),
	.rsp_last        (rsp.last)
);

// File: verif/bppm_pool_checker.sv
// ----------------------------------------------------------------------------
// bppm_pool_checker
// Watches the command and result channels of the buffer pool pin manager. It
// keeps its own copy of the slot pool, works out the result beats of every
// accepted command, and compares each result beat with the oldest one owed.
// ----------------------------------------------------------------------------
module bppm_pool_checker (
	input  logic clk,
	input  logic arst_n,
	bppm_req_if  req,
	bppm_rsp_if  rsp,
	output int   fail_count,
	output int   pending
);
	import bppm_pkg::*;

	// Shadow copy of the slot pool.
	logic               pool_valid [16];
	logic [BLOCK_W-1:0] pool_block [16];
	logic [PINS_W-1:0]  pool_pins  [16];
	logic               pool_dirty [16];

	// Result beats owed by the block, oldest first.
	result_t owed_results [$];
	result_t got;
	result_t want;
	int      mismatches = 0;

	function automatic result_t make_beat(
		input logic [STAT_W-1:0]  status,
		input int                 idx,
		input logic               wb,
		input logic [BLOCK_W-1:0] wb_block,
		input logic               load,
		input logic [PINS_W-1:0]  pins,
		input logic               last
	);
		result_t beat;
		beat.status           = status;
		beat.slot_index       = idx[SLOT_W-1:0];
		beat.write_back       = wb;
		beat.write_back_block = wb_block;
		beat.load_needed      = load;
		beat.pin_count        = pins;
		beat.last             = last;
		return beat;
	endfunction

	// Pin a slot; the count sticks at its maximum.
	function automatic void add_pin(input int i);
		if (pool_pins[i] != PINS_MAX) begin
			pool_pins[i] = pool_pins[i] + 8'd1;
		end
	endfunction

	// Applies one command to the shadow pool and queues the beats it owes.
	function automatic void predict_pool_results(
		input logic [CMD_W-1:0]   cmd,
		input logic [BLOCK_W-1:0] bid,
		input logic [SLOT_W-1:0]  slot_no
	);
		int   victim;
		int   hit;
		logic wb;
		victim = -1;
		hit    = -1;
		case (cmd)
			CMD_REQUEST: begin
				for (int i = 0; i < NSLOTS; i++) begin
					if (hit < 0 && pool_valid[i] && pool_block[i] == bid) begin
						hit = i;
					end
				end
				if (hit >= 0) begin
					add_pin(hit);
					owed_results.push_back(make_beat(ST_HIT, hit, 1'b0, '0, 1'b0,
						pool_pins[hit], 1'b1));
				end else begin
					// Victim: first empty slot, else first unpinned one.
					for (int i = 0; i < NSLOTS; i++) begin
						if (victim < 0 && !pool_valid[i]) begin
							victim = i;
						end
					end
					for (int i = 0; i < NSLOTS; i++) begin
						if (victim < 0 && pool_pins[i] == '0) begin
							victim = i;
						end
					end
					if (victim < 0) begin
						owed_results.push_back(make_beat(ST_NO_FREE, 0, 1'b0, '0, 1'b0,
							'0, 1'b1));
					end else begin
						wb = pool_valid[victim] && pool_dirty[victim];
						owed_results.push_back(make_beat(ST_LOADED, victim, wb,
							wb ? pool_block[victim] : '0, 1'b1,
							(pool_pins[victim] == PINS_MAX) ? PINS_MAX
								: pool_pins[victim] + 8'd1, 1'b1));
						pool_valid[victim] = 1'b1;
						pool_block[victim] = bid;
						pool_dirty[victim] = 1'b0;
						add_pin(victim);
					end
				end
			end
			CMD_RELEASE: begin
				if (int'(slot_no) < NSLOTS) begin
					if (pool_pins[slot_no] == '0) begin
						owed_results.push_back(make_beat(ST_UNDERFLOW, int'(slot_no), 1'b0,
							'0, 1'b0, '0, 1'b1));
					end else begin
						pool_pins[slot_no] = pool_pins[slot_no] - 8'd1;
						owed_results.push_back(make_beat(ST_RELEASED, int'(slot_no), 1'b0,
							'0, 1'b0, pool_pins[slot_no], 1'b1));
					end
				end
			end
			CMD_MARK: begin
				if (int'(slot_no) < NSLOTS) begin
					pool_dirty[slot_no] = 1'b1;
					owed_results.push_back(make_beat(ST_MARKED, int'(slot_no), 1'b0, '0,
						1'b0, pool_pins[slot_no], 1'b1));
				end
			end
			CMD_CLEAR: begin
				for (int i = 0; i < 16; i++) begin
					pool_valid[i] = 1'b0;
					pool_block[i] = '0;
					pool_pins[i]  = '0;
					pool_dirty[i] = 1'b0;
				end
				owed_results.push_back(make_beat(ST_CLEARED, 0, 1'b0, '0, 1'b0, '0, 1'b1));
			end
			CMD_FLUSH: begin
				// One beat per valid dirty slot, then the closing beat.
				for (int i = 0; i < NSLOTS; i++) begin
					if (pool_valid[i] && pool_dirty[i]) begin
						owed_results.push_back(make_beat(ST_FLUSH, i, 1'b1, pool_block[i],
							1'b0, pool_pins[i], 1'b0));
						pool_dirty[i] = 1'b0;
					end
				end
				owed_results.push_back(make_beat(ST_FLUSH, 0, 1'b0, '0, 1'b0, '0, 1'b1));
			end
			default: begin
			end
		endcase
	endfunction

	function automatic void note_failure(input string what, input result_t exp_beat,
		input result_t act_beat);
		if (mismatches < 10) begin
			$display("%0t: %s", $time, what);
			$display("  expected st=%0d slot=%0d wb=%0b blk=%h ld=%0b pins=%0d last=%0b",
				exp_beat.status, exp_beat.slot_index, exp_beat.write_back,
				exp_beat.write_back_block, exp_beat.load_needed, exp_beat.pin_count,
				exp_beat.last);
			$display("  actual   st=%0d slot=%0d wb=%0b blk=%h ld=%0b pins=%0d last=%0b",
				act_beat.status, act_beat.slot_index, act_beat.write_back,
				act_beat.write_back_block, act_beat.load_needed, act_beat.pin_count,
				act_beat.last);
		end
		mismatches++;
	endfunction

	// Predict on each accepted command beat, compare on each accepted result beat.
	always @(posedge clk) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				pool_valid[i] = 1'b0;
				pool_block[i] = '0;
				pool_pins[i]  = '0;
				pool_dirty[i] = 1'b0;
			end
			owed_results.delete();
		end else begin
			if (req.valid === 1'b1 && req.ready === 1'b1) begin
				predict_pool_results(req.command, req.block_id, req.slot);
			end
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
				got.status           = rsp.status;
				got.slot_index       = rsp.slot_index;
				got.write_back       = rsp.write_back;
				got.write_back_block = rsp.write_back_block;
				got.load_needed      = rsp.load_needed;
				got.pin_count        = rsp.pin_count;
				got.last             = rsp.last;
				if (owed_results.size() == 0) begin
					note_failure("result beat with none expected", '0, got);
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status || got.slot_index !== want.slot_index
						|| got.write_back !== want.write_back
						|| got.write_back_block !== want.write_back_block
						|| got.load_needed !== want.load_needed
						|| got.pin_count !== want.pin_count || got.last !== want.last) begin
						note_failure("result beat mismatch", want, got);
					end
				end
			end
		end
		fail_count <= mismatches;
		pending    <= owed_results.size();
	end

endmodule

// File: verif/tb_buffer_pool_pin_manager.sv
// ----------------------------------------------------------------------------
// tb_buffer_pool_pin_manager
// Drives commands into the buffer pool pin manager with random idling on both
// channels: a directed opening, a pin saturation run, then random traffic over
// a small set of block ids. The checker beside the block judges every result.
// ----------------------------------------------------------------------------
module tb_buffer_pool_pin_manager;
	import bppm_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int RANDOM_ITEMS  = 24;
	localparam int SATURATE_HITS = 258;
	localparam int ID_SET_SIZE   = 8;
	localparam int DRAIN_CYCLES  = 24;

	// Command codes the block has no use for.
	localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   calm   = 1'b0;
	int   cycles = 0;
	int   failures;
	int   owed;

	logic [BLOCK_W-1:0] id_set [ID_SET_SIZE];

	bppm_req_if req ();
	bppm_rsp_if rsp ();

	buffer_pool_pin_manager DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	bppm_pool_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.fail_count (failures),
		.pending    (owed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The result side stalls at random, except in the calm stretch.
	always @(posedge clk) begin
		rsp.ready <= calm || ($urandom_range(99) >= 9);
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offers one command beat, after a random idle spell, and waits for it to go.
	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] bid,
		input logic [SLOT_W-1:0] slot_no);
		while (!calm && $urandom_range(99) < 9) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.command  <= cmd;
		req.block_id <= bid;
		req.slot     <= slot_no;
		@(posedge clk);
		while (req.ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	initial begin
		int                 roll;
		logic [BLOCK_W-1:0] hot_id;
		req.valid    <= 1'b0;
		req.command  <= CMD_REQUEST;
		req.block_id <= '0;
		req.slot     <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-slot corner cases and unused codes.
		send_cmd(CMD_RELEASE, '0, 4'd5);
		send_cmd(CMD_MARK, '1, 4'd15);
		send_cmd(CMD_FLUSH, '0, '0);
		send_cmd(CMD_SPARE_LO, 32'h1234_5678, 4'd3);
		send_cmd(CMD_SPARE_HI, '1, '1);
		// Fill the whole pool, the dirty empty slot last, then hit and overflow.
		send_cmd(CMD_REQUEST, '0, '0);
		send_cmd(CMD_REQUEST, '1, '1);
		for (int k = 2; k < 16; k++) begin
			send_cmd(CMD_REQUEST, $urandom(), k[SLOT_W-1:0]);
		end
		send_cmd(CMD_REQUEST, '0, '0);
		send_cmd(CMD_REQUEST, 32'h5A5A_5A5A, '0);
		// Evict a dirty slot, then flush one dirty slot and clear.
		send_cmd(CMD_MARK, '0, 4'd1);
		send_cmd(CMD_RELEASE, '0, 4'd1);
		send_cmd(CMD_REQUEST, 32'hA5A5_A5A5, '0);
		send_cmd(CMD_MARK, '0, 4'd0);
		send_cmd(CMD_FLUSH, '0, '0);
		send_cmd(CMD_CLEAR, '0, '0);

		// Saturation: pin one block past the top of its count, with no
		// idling on either side.
		calm   = 1'b1;
		hot_id = $urandom();
		for (int k = 0; k < SATURATE_HITS; k++) begin
			send_cmd(CMD_REQUEST, hot_id, SLOT_W'($urandom_range(15)));
		end
		calm = 1'b0;
		send_cmd(CMD_RELEASE, $urandom(), 4'd0);
		send_cmd(CMD_MARK, $urandom(), 4'd0);
		send_cmd(CMD_FLUSH, $urandom(), SLOT_W'($urandom_range(15)));
		send_cmd(CMD_CLEAR, $urandom(), SLOT_W'($urandom_range(15)));

		// Random traffic: requests mostly from a small id set, so that hits
		// and evictions occur.
		foreach (id_set[j]) begin
			id_set[j] = $urandom();
		end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			roll = int'($urandom_range(99));
			if (roll < 45) begin
				send_cmd(CMD_REQUEST,
					($urandom_range(9) == 0) ? $urandom() : id_set[$urandom_range(ID_SET_SIZE-1)],
					SLOT_W'($urandom_range(15)));
			end else if (roll < 70) begin
				send_cmd(CMD_RELEASE, $urandom(), SLOT_W'($urandom_range(15)));
			end else if (roll < 85) begin
				send_cmd(CMD_MARK, $urandom(), SLOT_W'($urandom_range(15)));
			end else if (roll < 93) begin
				send_cmd(CMD_FLUSH, $urandom(), SLOT_W'($urandom_range(15)));
			end else if (roll < 96) begin
				send_cmd(CMD_CLEAR, $urandom(), SLOT_W'($urandom_range(15)));
			end else begin
				send_cmd(CMD_W'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO)), $urandom(),
					SLOT_W'($urandom_range(15)));
			end
		end
		req.valid <= 1'b0;

		// Let the last command reach the checker, drain what is still owed,
		// then watch for stray beats.
		@(posedge clk);
		while (owed != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (failures == 0 && owed == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/bppm_pkg.sv
rtl/core/bppm_req_if.sv
rtl/core/bppm_rsp_if.sv
rtl/core/bppm_slot_store.sv
rtl/core/bppm_out_stage.sv
rtl/core/bppm_seq.sv
rtl/core/buffer_pool_pin_manager.sv
rtl/core/bppm_checker.sv
verif/bppm_pool_checker.sv
verif/tb_buffer_pool_pin_manager.sv
